/* src/ida_pkg.sv */
`default_nettype none

package ida_pkg;

    localparam int MAX_IDS  = 16;
    localparam int SLOT_W   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int CNT_W    = $clog2(MAX_IDS + 1);
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [ID_W-1:0]   id_t;

    localparam id_t FIRST_ID_RESET = 16'd101;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_FREED     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NONE_LIVE = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        slot_t push_slot;
    } fifo_req_t;

    typedef struct packed {
        logic   empty;
        logic   full;
        count_t fill;
        slot_t  head_slot;
    } fifo_stat_t;

endpackage

`default_nettype wire

/* src/ida_slot_fifo.sv */
`default_nettype none

module ida_slot_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ida_pkg::fifo_req_t req,
    output ida_pkg::fifo_stat_t     stat
);
    import ida_pkg::*;

    slot_t                mem_reg [MAX_IDS];
    slot_t                head_reg;
    slot_t                head_next;
    count_t               fill_reg;
    count_t               fill_next;
    logic [SLOT_W:0]      tail_sum;
    slot_t                tail;
    logic                 do_push;
    logic                 do_pop;

    always_comb begin
        stat.empty     = (fill_reg == '0);
        stat.full      = (fill_reg == CNT_W'(MAX_IDS));
        stat.fill      = fill_reg;
        stat.head_slot = mem_reg[head_reg];

        do_push = req.push && !stat.full;
        do_pop  = req.pop && !stat.empty;

        tail_sum = (SLOT_W + 1)'(head_reg) + (SLOT_W + 1)'(fill_reg);
        if (tail_sum >= (SLOT_W + 1)'(MAX_IDS)) begin
            tail = SLOT_W'(tail_sum - (SLOT_W + 1)'(MAX_IDS));
        end else begin
            tail = SLOT_W'(tail_sum);
        end

        head_next = head_reg;
        fill_next = fill_reg;
        if (do_pop) begin
            head_next = (head_reg == SLOT_W'(MAX_IDS - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end else if (do_push) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[tail] <= req.push_slot;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.push && req.pop))
        else $error("recycle queue asked to push and pop in the same cycle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_IDS))
        else $error("recycle queue fill count beyond its depth");

endmodule

`default_nettype wire

/* src/id_allocator_with_recycle_fifo.sv */
// Identifier allocator with a recycle queue.
// Input channel s_*: s_tuser carries the opcode (allocate or free) and s_tdata the
// identifier to free, which is ignored for an allocate item. Result channel m_*:
// m_tuser carries the status and m_tdata the identifier allocated or freed, or zero.
// The cfg_* channel writes first_id, the identifier of slot 0; it is always ready,
// and the user must write it only while the block is idle; the block does not enforce it.
// Each accepted item is decided in the cycle it is accepted, against the live map,
// the recycle queue and the fresh counter, and its result is registered: the result
// is presented in the cycle after acceptance. One item is accepted per cycle for as
// long as the receiver takes results; the single output register decouples the two
// sides, and s_tready falls only while a result waits and m_tready is low.
// Allocation pops the oldest freed slot, else issues the next fresh slot, else
// reports exhausted. Reset clears the live map, the counters, the queue pointers and
// the output valid flag, and sets first_id to 101.
`default_nettype none

module id_allocator_with_recycle_fifo (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [15:0] s_tdata,  // [15:0] id_in
    input  wire logic [0:0] s_tuser,   // [0] opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,   // [15:0] id_out
    output logic [2:0]      m_tuser,   // [2:0] status
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import ida_pkg::*;

    id_t                 first_id_reg;
    count_t              fresh_count_reg;
    count_t              fresh_count_next;
    logic [MAX_IDS-1:0]  live_map_reg;
    logic [MAX_IDS-1:0]  live_map_next;
    count_t              live_total_reg;
    count_t              live_total_next;
    logic                m_valid_reg;
    status_t             m_status_reg;
    status_t             status_next;
    id_t                 m_id_reg;
    id_t                 id_next;
    fifo_req_t           fifo_req;
    fifo_stat_t          fifo_stat;
    logic                in_fire;
    opcode_t             opcode;
    id_t                 id_diff;
    logic                diff_in_range;
    slot_t               free_slot;
    slot_t               alloc_slot;
    logic                got_slot;

    ida_slot_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fifo_req),
        .stat    (fifo_stat)
    );

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_id_reg;
    assign m_tuser   = m_status_reg;

    always_comb begin
        opcode        = opcode_t'(s_tuser[0]);
        id_diff       = s_tdata - first_id_reg;
        diff_in_range = (id_diff < ID_W'(MAX_IDS));
        free_slot     = SLOT_W'(id_diff);

        fresh_count_next = fresh_count_reg;
        live_map_next    = live_map_reg;
        live_total_next  = live_total_reg;
        fifo_req         = '0;
        alloc_slot       = '0;
        got_slot         = 1'b0;
        status_next      = ST_EXHAUSTED;
        id_next          = '0;

        if (opcode == OP_ALLOC) begin
            if (!fifo_stat.empty) begin
                alloc_slot   = fifo_stat.head_slot;
                got_slot     = 1'b1;
                fifo_req.pop = in_fire;
            end else if (fresh_count_reg < CNT_W'(MAX_IDS)) begin
                alloc_slot = SLOT_W'(fresh_count_reg);
                got_slot   = 1'b1;
                if (in_fire) begin
                    fresh_count_next = fresh_count_reg + 1'b1;
                end
            end
            if (got_slot) begin
                status_next = ST_ALLOCATED;
                id_next     = first_id_reg + ID_W'(alloc_slot);
                if (in_fire && !live_map_reg[alloc_slot]) begin
                    live_map_next[alloc_slot] = 1'b1;
                    live_total_next           = live_total_reg + 1'b1;
                end
            end
        end else begin
            if (live_total_reg == '0) begin
                status_next = ST_NONE_LIVE;
            end else if (!diff_in_range || !live_map_reg[free_slot]) begin
                status_next = ST_NOT_FOUND;
            end else begin
                status_next        = ST_FREED;
                id_next            = s_tdata;
                fifo_req.push_slot = free_slot;
                if (in_fire) begin
                    live_map_next[free_slot] = 1'b0;
                    live_total_next          = live_total_reg - 1'b1;
                    fifo_req.push            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_id_reg    <= FIRST_ID_RESET;
            fresh_count_reg <= '0;
            live_map_reg    <= '0;
            live_total_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                first_id_reg <= cfg_data;
            end
            fresh_count_reg <= fresh_count_next;
            live_map_reg    <= live_map_next;
            live_total_reg  <= live_total_next;
            if (in_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_status_reg <= status_next;
            m_id_reg     <= id_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        live_total_reg == CNT_W'($countones(live_map_reg)))
        else $error("live total disagrees with the live map");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W + 1)'(live_total_reg) + (CNT_W + 1)'(fifo_stat.fill)
            == (CNT_W + 1)'(fresh_count_reg))
        else $error("issued slots are neither live nor queued");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_NOT_FOUND || m_status_reg == ST_NONE_LIVE
            || m_status_reg == ST_EXHAUSTED) |-> m_id_reg == '0)
        else $error("failed request carries a non-zero identifier");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && opcode == OP_FREE && live_total_reg == '0
            |=> m_status_reg == ST_NONE_LIVE)
        else $error("free with nothing live not reported as such");

endmodule

`default_nettype wire
